>>> sv/spr_pkg.sv
package spr_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_SLOTS  = 1024;
    localparam int HDR_BYTES  = 6;
    localparam int SLOT_COST  = 4;

    // pointer holds 0..PAGE_BYTES, byte address 0..PAGE_BYTES-1
    localparam int PTR_W  = $clog2(PAGE_BYTES) + 1;
    localparam int ADDR_W = $clog2(PAGE_BYTES);
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    // fixed field widths of the stream items
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 10;
    localparam int LEN_W    = 13;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int NEED_W   = ((LEN_W > PTR_W) ? LEN_W : PTR_W) + 1;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_VALID = 2'd3
    } status_t;

    typedef struct packed {
        logic [IN_TDATA_W-ID_W-LEN_W-BYTE_W-1:0] pad;
        logic [BYTE_W-1:0]                       data_byte;
        logic [LEN_W-1:0]                        rec_len;
        logic [ID_W-1:0]                         slot_id;
    } in_item_t;

    typedef struct packed {
        logic [OUT_TDATA_W-STATUS_W-2*ID_W-LEN_W-1:0] pad;
        logic [ID_W-1:0]                              slots_used;
        logic [LEN_W-1:0]                             free_bytes;
        logic [ID_W-1:0]                              slot_no;
        logic [STATUS_W-1:0]                          status;
    } out_item_t;

    // slot table entry; offset 0 marks a deleted slot
    typedef struct packed {
        logic [PTR_W-1:0]  off;
        logic [ADDR_W-1:0] len;
    } slot_ent_t;

endpackage

>>> sv/slotted_page_record_store.sv
// Slotted page record store. One operation is a run of requests ended by
// s_tlast; the first request carries the operation (s_tuser), slot id and
// record length, every request carries one record byte, and the request
// with s_tlast yields one result on the m side. Each request takes one
// cycle, except the first request of a delete or update whose slot id is
// below the slot count, which takes two: the slot table is a single
// synchronous memory and its entry must be read before the slot can be
// checked. Page bytes and the slot table have no reset and need no clearing
// pass; slot entries are only read below the slot count. A waiting result
// holds up every request until it is taken.
module slotted_page_record_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // slot_id [9:0], rec_len [22:10], data_byte [30:23], zero [31]
    input  logic [spr_pkg::IN_TDATA_W-1:0] s_tdata,
    // func [1:0]
    input  logic [spr_pkg::FUNC_W-1:0]     s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [1:0], slot_no [11:2], free_bytes [24:12], slots_used [34:25],
    // zero [39:35]
    output logic [spr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import spr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DATA
    } state_t;

    state_t           state_reg,      state_next;
    logic [CNT_W-1:0] total_reg,      total_next;
    logic [PTR_W-1:0] fstart_reg,     fstart_next;
    logic [PTR_W-1:0] fend_reg,       fend_next;
    logic [PTR_W-1:0] wptr_reg,       wptr_next;
    logic [PTR_W-1:0] left_reg,       left_next;
    status_t          op_status_reg,  op_status_next;
    logic [ID_W-1:0]  op_slot_reg,    op_slot_next;
    op_t              op_func_reg,    op_func_next;
    logic [BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic             hold_last_reg,  hold_last_next;
    logic             out_valid_reg,  out_valid_next;
    out_item_t        out_data_reg,   out_data_next;

    slot_ent_t page_dummy_unused;
    logic [BYTE_W-1:0] page_mem [PAGE_BYTES];
    slot_ent_t         slot_mem [MAX_SLOTS];
    slot_ent_t         slot_rd_reg;

    logic              pg_we;
    logic [ADDR_W-1:0] pg_addr;
    logic [BYTE_W-1:0] pg_din;
    logic              sl_we;
    logic [SLOT_W-1:0] sl_waddr;
    slot_ent_t         sl_din;
    logic              sl_re;
    logic [SLOT_W-1:0] sl_raddr;

    in_item_t          in_item;
    logic              accept;
    logic [PTR_W-1:0]  free_cur;
    logic [PTR_W-1:0]  free_next;
    logic [NEED_W-1:0] need;
    logic [PTR_W-1:0]  new_off;
    logic              byte_en;
    logic [PTR_W-1:0]  wp;
    logic [PTR_W-1:0]  bl;
    logic [BYTE_W-1:0] wbyte;
    logic              finish;

    assign in_item  = in_item_t'(s_tdata);
    assign s_tready = (state_reg != S_LOOKUP) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    assign free_cur = (fend_reg >= fstart_reg) ? fend_reg - fstart_reg : '0;
    assign need     = NEED_W'(in_item.rec_len) + NEED_W'(SLOT_COST);
    assign new_off  = fend_reg - PTR_W'(in_item.rec_len);
    assign page_dummy_unused = '0;

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        fstart_next    = fstart_reg;
        fend_next      = fend_reg;
        wptr_next      = wptr_reg;
        left_next      = left_reg;
        op_status_next = op_status_reg;
        op_slot_next   = op_slot_reg;
        op_func_next   = op_func_reg;
        hold_byte_next = hold_byte_reg;
        hold_last_next = hold_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        sl_we    = 1'b0;
        sl_waddr = total_reg[SLOT_W-1:0];
        sl_din   = page_dummy_unused;
        sl_re    = 1'b0;
        sl_raddr = in_item.slot_id[SLOT_W-1:0];

        byte_en = 1'b0;
        wp      = wptr_reg;
        bl      = left_reg;
        wbyte   = in_item.data_byte;
        finish  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_func_next   = op_t'(s_tuser);
                    op_status_next = ST_OK;
                    op_slot_next   = '0;
                    wp             = '0;
                    bl             = '0;
                    byte_en        = 1'b1;
                    finish         = s_tlast;
                    unique case (op_t'(s_tuser))
                        OP_INSERT:
                        begin
                            if (NEED_W'(free_cur) < need || total_reg >= CNT_W'(MAX_SLOTS))
                            begin
                                op_status_next = ST_NO_SPACE;
                            end
                            else
                            begin
                                sl_we        = 1'b1;
                                sl_din.off   = new_off;
                                sl_din.len   = ADDR_W'(in_item.rec_len);
                                op_slot_next = ID_W'(total_reg);
                                total_next   = total_reg + CNT_W'(1);
                                fend_next    = new_off;
                                fstart_next  = fstart_reg + PTR_W'(SLOT_COST);
                                wp           = new_off;
                                bl           = PTR_W'(in_item.rec_len);
                            end
                        end
                        OP_DELETE, OP_UPDATE:
                        begin
                            op_slot_next = in_item.slot_id;
                            if (CNT_W'(in_item.slot_id) >= total_reg)
                            begin
                                op_status_next = ST_RANGE;
                            end
                            else
                            begin
                                // slot entry comes back next cycle
                                sl_re          = 1'b1;
                                hold_byte_next = in_item.data_byte;
                                hold_last_next = s_tlast;
                                byte_en        = 1'b0;
                                finish         = 1'b0;
                                state_next     = S_LOOKUP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            total_next  = '0;
                            fstart_next = PTR_W'(HDR_BYTES);
                            fend_next   = PTR_W'(PAGE_BYTES);
                        end
                        default:
                        begin
                        end
                    endcase
                    if (state_next == S_IDLE && !s_tlast)
                    begin
                        state_next = S_DATA;
                    end
                end
            end
            S_LOOKUP:
            begin
                wp      = '0;
                bl      = '0;
                wbyte   = hold_byte_reg;
                byte_en = 1'b1;
                finish  = hold_last_reg;
                if (slot_rd_reg.off == '0)
                begin
                    op_status_next = ST_NOT_VALID;
                end
                else if (op_func_reg == OP_DELETE)
                begin
                    sl_we    = 1'b1;
                    sl_waddr = op_slot_reg[SLOT_W-1:0];
                    sl_din   = page_dummy_unused;
                end
                else
                begin
                    wp = slot_rd_reg.off;
                    bl = PTR_W'(slot_rd_reg.len);
                end
                state_next = hold_last_reg ? S_IDLE : S_DATA;
            end
            S_DATA:
            begin
                if (accept)
                begin
                    byte_en = 1'b1;
                    finish  = s_tlast;
                    if (s_tlast)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one record byte per request while the record is not yet full
        pg_we   = 1'b0;
        pg_addr = wp[ADDR_W-1:0];
        pg_din  = wbyte;
        if (byte_en)
        begin
            wptr_next = wp;
            left_next = bl;
            if (bl != '0)
            begin
                pg_we     = (wp < PTR_W'(PAGE_BYTES));
                wptr_next = wp + PTR_W'(1);
                left_next = bl - PTR_W'(1);
            end
        end

        free_next = (fend_next >= fstart_next) ? fend_next - fstart_next : '0;
        if (finish)
        begin
            left_next                = '0;
            out_valid_next           = 1'b1;
            out_data_next.pad        = '0;
            out_data_next.status     = op_status_next;
            out_data_next.slot_no    = op_slot_next;
            out_data_next.free_bytes = LEN_W'(free_next);
            out_data_next.slots_used = ID_W'(total_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            fstart_reg    <= PTR_W'(HDR_BYTES);
            fend_reg      <= PTR_W'(PAGE_BYTES);
            wptr_reg      <= '0;
            left_reg      <= '0;
            op_status_reg <= ST_OK;
            op_slot_reg   <= '0;
            op_func_reg   <= OP_INSERT;
            hold_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            fstart_reg    <= fstart_next;
            fend_reg      <= fend_next;
            wptr_reg      <= wptr_next;
            left_reg      <= left_next;
            op_status_reg <= op_status_next;
            op_slot_reg   <= op_slot_next;
            op_func_reg   <= op_func_next;
            hold_last_reg <= hold_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_mem[pg_addr] <= pg_din;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            slot_mem[sl_waddr] <= sl_din;
        end
        if (sl_re)
        begin
            slot_rd_reg <= slot_mem[sl_raddr];
        end
    end

endmodule

>>> sv/spr_checker.sv
module spr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [spr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic [spr_pkg::FUNC_W-1:0]      s_tuser,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [spr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import spr_pkg::*;

    out_item_t        res;
    logic             last_acc;
    logic [CNT_W+2:0] used_bytes;

    assign res        = out_item_t'(m_tdata);
    assign last_acc   = s_tvalid && s_tready && s_tlast;
    assign used_bytes = (CNT_W+3)'(res.free_bytes) + (CNT_W+3)'({res.slots_used, 2'b00});

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // free space and the slot table never overlap the header
    a_space: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> used_bytes <= (CNT_W+3)'(PAGE_BYTES - HDR_BYTES))
        else $error("free space plus slot table exceeds page");

    // a refused insert reports no slot
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.status == ST_NO_SPACE |-> res.slot_no == '0)
        else $error("refused insert reports a slot");

    // a new result comes from an accepted last request, directly or through the slot lookup
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(last_acc, 1) || $past(last_acc, 2))
        else $error("result without a last request");

endmodule

bind slotted_page_record_store spr_checker u_spr_checker (.*);

>>> dv/tb_slotted_page_record_store.sv
`timescale 1ns / 1ps

module tb_slotted_page_record_store;
    import spr_pkg::*;

    typedef struct {
        op_t               func;
        logic [ID_W-1:0]   slot_id;
        logic [LEN_W-1:0]  rec_len;
        logic [BYTE_W-1:0] data_byte;
        logic              is_last;
    } page_req_t;

    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   slot_no;
        logic [LEN_W-1:0]  free_bytes;
        logic [ID_W-1:0]   slots_used;
    } page_result_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]      s_tuser  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    page_req_t    req_pending[$];
    page_result_t results_due[$];
    page_req_t    req_on_bus;
    out_item_t    res_got;
    page_result_t res_want;

    int req_queued   = 0;
    int req_taken    = 0;
    int err_cnt      = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_tx      = 1'b0;

    // Shadow bookkeeping of the page. Record bytes never come back out, so
    // only slot offsets (0 = deleted), the slot count and the free pointers
    // are tracked.
    int      shd_off[MAX_SLOTS];
    int      shd_count  = 0;
    int      shd_lo     = HDR_BYTES;
    int      shd_hi     = PAGE_BYTES;
    bit      shd_in_op  = 1'b0;
    status_t shd_status = ST_OK;
    int      shd_slot   = 0;

    slotted_page_record_store i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic void apply_page_request(page_req_t r);
        page_result_t res;
        int           id;
        int           len;
        id  = r.slot_id;
        len = r.rec_len;
        if (!shd_in_op)
        begin
            shd_in_op  = 1'b1;
            shd_status = ST_OK;
            shd_slot   = 0;
            case (r.func)
                OP_INSERT:
                begin
                    if (shd_hi - shd_lo < len + SLOT_COST || shd_count >= MAX_SLOTS)
                    begin
                        shd_status = ST_NO_SPACE;
                    end
                    else
                    begin
                        shd_hi             = shd_hi - len;
                        shd_off[shd_count] = shd_hi;
                        shd_slot           = shd_count;
                        shd_count          = shd_count + 1;
                        shd_lo             = shd_lo + SLOT_COST;
                    end
                end
                OP_DELETE, OP_UPDATE:
                begin
                    shd_slot = id;
                    if (id >= shd_count)
                    begin
                        shd_status = ST_RANGE;
                    end
                    else if (shd_off[id] == 0)
                    begin
                        shd_status = ST_NOT_VALID;
                    end
                    else if (r.func == OP_DELETE)
                    begin
                        // space and slot count are not given back
                        shd_off[id] = 0;
                    end
                end
                default:
                begin
                    shd_count = 0;
                    shd_lo    = HDR_BYTES;
                    shd_hi    = PAGE_BYTES;
                end
            endcase
        end
        if (r.is_last)
        begin
            shd_in_op      = 1'b0;
            res.status     = shd_status;
            res.slot_no    = ID_W'(shd_slot);
            res.free_bytes = LEN_W'(shd_hi - shd_lo);
            res.slots_used = ID_W'(shd_count);
            results_due.push_back(res);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_page_request(req_on_bus);
                req_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_pending.size() != 0 && !hold_tx && $urandom_range(99) >= tx_idle_pct)
                begin
                    req_on_bus = req_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, req_on_bus.data_byte, req_on_bus.rec_len,
                                 req_on_bus.slot_id};
                    s_tuser  <= req_on_bus.func;
                    s_tlast  <= req_on_bus.is_last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                res_got = m_tdata;
                if (results_due.size() == 0)
                begin
                    $error({"result with none expected: status %0d slot_no %0d",
                            " free_bytes %0d slots_used %0d"},
                           res_got.status, res_got.slot_no, res_got.free_bytes,
                           res_got.slots_used);
                    err_cnt++;
                end
                else
                begin
                    res_want = results_due.pop_front();
                    if (res_got.status != res_want.status)
                    begin
                        $error("status: expected %0d, got %0d", res_want.status, res_got.status);
                        err_cnt++;
                    end
                    if (res_got.slot_no != res_want.slot_no)
                    begin
                        $error("slot_no: expected %0d, got %0d", res_want.slot_no,
                               res_got.slot_no);
                        err_cnt++;
                    end
                    if (res_got.free_bytes != res_want.free_bytes)
                    begin
                        $error("free_bytes: expected %0d, got %0d", res_want.free_bytes,
                               res_got.free_bytes);
                        err_cnt++;
                    end
                    if (res_got.slots_used != res_want.slots_used)
                    begin
                        $error("slots_used: expected %0d, got %0d", res_want.slots_used,
                               res_got.slots_used);
                        err_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // One operation of n requests. The operation, slot id and length fields of
    // the later requests are ignored by the block, so they carry random values.
    task automatic queue_page_op(op_t f, int id, int len, int n, int first_byte = -1);
        page_req_t r;
        for (int k = 0; k < n; k++)
        begin
            if (k == 0)
            begin
                r.func    = f;
                r.slot_id = ID_W'(id);
                r.rec_len = LEN_W'(len);
            end
            else
            begin
                r.func    = op_t'($urandom_range(3));
                r.slot_id = ID_W'($urandom_range(1023));
                r.rec_len = LEN_W'($urandom_range(8191));
            end
            r.data_byte = (k == 0 && first_byte >= 0) ? BYTE_W'(first_byte)
                                                      : BYTE_W'($urandom_range(255));
            r.is_last   = (k == n - 1);
            req_pending.push_back(r);
            req_queued++;
        end
    endtask

    task automatic queue_random_op();
        int  pick;
        int  id;
        int  len;
        int  n;
        op_t f;
        pick = $urandom_range(99);
        id   = ($urandom_range(9) < 8) ? $urandom_range(15) : $urandom_range(1023);
        len  = 0;
        if (pick < 40)
        begin
            f    = OP_INSERT;
            pick = $urandom_range(9);
            if (pick < 7)
                len = $urandom_range(16);
            else if (pick < 9)
                len = $urandom_range(4096, 17);
            else
                len = $urandom_range(8191, 4097);
            if (len > 16)
                n = $urandom_range(4, 1);   // short record
            else if (len == 0)
                n = $urandom_range(2, 1);
            else
            begin
                pick = $urandom_range(9);
                if (pick < 7)
                    n = len;
                else if (pick < 8)
                    n = $urandom_range(len, 1);
                else
                    n = len + $urandom_range(3, 1);
            end
        end
        else if (pick < 60)
        begin
            f = OP_DELETE;
            n = $urandom_range(3, 1);
        end
        else if (pick < 85)
        begin
            f = OP_UPDATE;
            n = $urandom_range(8, 1);
        end
        else if (pick < 90)
        begin
            f = OP_CLEAR;
            n = $urandom_range(2, 1);
        end
        else
        begin
            f   = op_t'($urandom_range(3));
            id  = $urandom_range(1023);
            len = $urandom_range(8191);
            n   = $urandom_range(6, 1);
        end
        queue_page_op(f, id, len, n);
    endtask

    // nothing on the bus and no result outstanding
    task automatic wait_page_quiet();
        while (req_queued - req_pending.size() != req_taken || results_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_page_op(OP_INSERT, 0, 0, 1, 0);        // zero length record
        queue_page_op(OP_INSERT, 1023, 3, 3, 255);
        queue_page_op(OP_INSERT, 0, 2, 3);           // surplus bytes dropped
        queue_page_op(OP_INSERT, 0, 5, 2);           // short record
        queue_page_op(OP_UPDATE, 3, 0, 5);           // length taken from the stored slot
        queue_page_op(OP_DELETE, 1, 0, 1);
        queue_page_op(OP_DELETE, 1, 0, 1);           // already deleted
        queue_page_op(OP_UPDATE, 1, 0, 2);           // deleted slot
        queue_page_op(OP_DELETE, 1023, 0, 2);        // out of range, extra request drained
        queue_page_op(OP_UPDATE, 4, 0, 1);           // one past the count
        queue_page_op(OP_INSERT, 0, 8191, 1);        // no space
        queue_page_op(OP_INSERT, 0, 4060, 1);        // takes the last free byte
        queue_page_op(OP_INSERT, 0, 0, 1);           // slot cost alone does not fit
        queue_page_op(OP_CLEAR, 0, 0, 2);
        queue_page_op(OP_DELETE, 0, 0, 1);           // empty page
        while (req_pending.size() != 0)
            @(posedge clk);
        wait_page_quiet();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            target = req_queued + 100;
            while (req_queued < target)
                queue_random_op();
            if (ph == 0)
            begin
                while (req_pending.size() > 50)
                    @(posedge clk);
                hold_tx = 1'b1;
                wait_page_quiet();
                hold_tx = 1'b0;
            end
            while (req_pending.size() != 0)
                @(posedge clk);
            wait_page_quiet();
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/spr_pkg.sv
sv/slotted_page_record_store.sv
sv/spr_checker.sv
dv/tb_slotted_page_record_store.sv
